### src/sd_spi_host_sequencer_top_defines.svh
// Assertion macros shared by the SD SPI host sequencer RTL.
// No dependencies.
`ifndef SD_SPI_HOST_SEQUENCER_TOP_DEFINES_SVH
`define SD_SPI_HOST_SEQUENCER_TOP_DEFINES_SVH
// assert that a condition implies a consequence in the same cycle
`define SDS_ASSERT_IMP(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("sds assertion failed");
// assert that a condition implies a consequence in the following cycle
`define SDS_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("sds assertion failed");
`endif

### src/sds_pkg.sv
// Package for the SD SPI host sequencer: phases, codes, result struct.
// No dependencies.
`default_nettype none
package sds_pkg;
  localparam int BLOCK_BYTES = 512;
  localparam int CLOCK_TRAIN_BYTES = 10;
  localparam int INIT_ROUNDS = 10;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0, OP_READ = 2'd1, OP_WRITE = 2'd2, OP_XFER = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_RESP_POLL = 2'd0, CFG_RETRY = 2'd1, CFG_BUSY_POLL = 2'd2, CFG_NONE = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_TRAIN, PH_PRE, PH_CMD, PH_RESP, PH_TRAIL, PH_DESEL, PH_DESEL_FIN,
    PH_RD_TOKEN, PH_RD_DATA, PH_RD_CRC, PH_WR_GAP, PH_WR_TOKEN, PH_WR_DATA,
    PH_WR_CRC, PH_WR_DRESP, PH_WR_BUSY
  } phase_t;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_CMD0 = 3'd1;
  localparam logic [2:0] ST_CMD8 = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_ACMD41 = 3'd4;
  localparam logic [2:0] ST_OCR = 3'd5;
  localparam logic [2:0] ST_CMD16 = 3'd6;
  localparam logic [2:0] ST_BLOCK = 3'd7;

  localparam logic [5:0] CMD0 = 6'd0;
  localparam logic [5:0] CMD8 = 6'd8;
  localparam logic [5:0] CMD16 = 6'd16;
  localparam logic [5:0] CMD17 = 6'd17;
  localparam logic [5:0] CMD24 = 6'd24;
  localparam logic [5:0] CMD41 = 6'd41;
  localparam logic [5:0] CMD55 = 6'd55;
  localparam logic [5:0] CMD58 = 6'd58;

  typedef struct packed {
    logic        tr;
    logic [7:0]  mosi;
    logic        cs;
    logic        rv;
    logic [7:0]  rb;
    logic        need;
    logic        done;
    logic [2:0]  status;
    logic        hc;
    logic [31:0] ocr;
  } res_t;
endpackage
`default_nettype wire

### src/sd_spi_host_sequencer_top.sv
// Results are registered on acceptance; the decision is a single combinational pass.
// Throughput: one item per cycle unless the output register is full and not drained.
// An output skid-free register accepts a new item whenever it is empty or being drained.
// Reset (rst_n low, synchronous): phase idle, counters cleared, limits 50, 25, 1300000.
// Top level of the SD SPI host sequencer; depends on sds_pkg, sds_core and defines header.
`default_nettype none
`include "sd_spi_host_sequencer_top_defines.svh"
module sd_spi_host_sequencer_top import sds_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // operation[1:0], block_address[33:2], miso_byte[41:34], write_byte[49:42], zero pad
  input  wire logic [55:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: transfer_request, mosi_byte, chip_select_active, read_valid, read_byte,
  // need_write_byte, status, high_capacity, ocr_value (low bit up)
  output logic [55:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [20:0] cfg_data
);
  logic [7:0]  rlim_r;
  logic [7:0]  rtry_r;
  logic [20:0] blim_r;
  logic        ov_r;
  res_t        res;
  res_t        out_r;
  logic        step;

  assign s_axis_tready = !ov_r || m_axis_tready;
  assign step = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  sds_core u_core (
    .clk(clk), .rst_n(rst_n), .step(step),
    .op(s_axis_tdata[1:0]), .addr(s_axis_tdata[33:2]),
    .miso(s_axis_tdata[41:34]), .wb(s_axis_tdata[49:42]),
    .resp_lim(rlim_r), .retry_lim(rtry_r), .busy_lim(blim_r), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rlim_r <= 8'd50; rtry_r <= 8'd25; blim_r <= 21'd1300000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RESP_POLL: rlim_r <= cfg_data[7:0];
        CFG_RETRY: rtry_r <= cfg_data[7:0];
        CFG_BUSY_POLL: blim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (step) ov_r <= 1'b1;
    else if (m_axis_tready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (step) out_r <= res;
  end

  assign m_axis_tvalid = ov_r;
  assign m_axis_tlast = out_r.done;
  assign m_axis_tdata = {out_r.ocr, out_r.hc, out_r.status, out_r.need, out_r.rb,
                         out_r.rv, out_r.cs, out_r.mosi, out_r.tr};

  `SDS_ASSERT_NEXT(a_step_valid, step, m_axis_tvalid)
  `SDS_ASSERT_IMP(a_stall_ready, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `SDS_ASSERT_IMP(a_last_quiet, m_axis_tvalid && m_axis_tlast, !m_axis_tdata[0])
endmodule
`default_nettype wire

### src/sds_core.sv
// Sequencer core: phase state, counters and combinational next-byte decision.
// Depends on sds_pkg and the assertion macro header.
`default_nettype none
`include "sd_spi_host_sequencer_top_defines.svh"
module sds_core import sds_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [1:0]  op,
  input  wire logic [31:0] addr,
  input  wire logic [7:0]  miso,
  input  wire logic [7:0]  wb,
  input  wire logic [7:0]  resp_lim,
  input  wire logic [7:0]  retry_lim,
  input  wire logic [20:0] busy_lim,
  output res_t             res
);
  phase_t      phase_r, phase_nxt;
  logic [9:0]  bc_r, bc_nxt;
  logic [20:0] pc_r, pc_nxt;
  logic [7:0]  rc_r, rc_nxt;
  logic [3:0]  orc_r, orc_nxt;
  logic [31:0] ocr_r, ocr_nxt;
  logic        hc_r, hc_nxt;
  logic [31:0] arg_r, arg_nxt;
  logic [5:0]  cmd_r, cmd_nxt;
  logic [7:0]  r1_r, r1_nxt;
  logic [2:0]  fs_r, fs_nxt;
  logic [20:0] pc_inc;
  logic [7:0]  rlim;
  logic [20:0] blim;
  logic [7:0]  r1v;
  logic        rdone;

  assign pc_inc = pc_r + 21'd1;
  assign rlim = (resp_lim == 8'd0) ? 8'd1 : resp_lim;
  assign blim = (busy_lim == 21'd0) ? 21'd1 : busy_lim;

  always_comb begin
    phase_nxt = phase_r; bc_nxt = bc_r; pc_nxt = pc_r; rc_nxt = rc_r; orc_nxt = orc_r;
    ocr_nxt = ocr_r; hc_nxt = hc_r; arg_nxt = arg_r; cmd_nxt = cmd_r; r1_nxt = r1_r;
    fs_nxt = fs_r;
    res = '0;
    r1v = 8'hFF; rdone = 1'b0;
    if (op == OP_INIT) begin
      phase_nxt = PH_TRAIN; bc_nxt = '0; res.tr = 1'b1; res.mosi = 8'hFF;
    end else if (op == OP_READ || op == OP_WRITE) begin
      cmd_nxt = (op == OP_READ) ? CMD17 : CMD24;
      arg_nxt = hc_r ? addr : {addr[22:0], 9'd0};
      phase_nxt = PH_PRE; res.tr = 1'b1; res.mosi = 8'hFF; res.cs = 1'b1;
    end else begin
      unique case (phase_r)
        PH_IDLE: ;
        PH_TRAIN: begin
          bc_nxt = bc_r + 10'd1;
          res.tr = 1'b1; res.mosi = 8'hFF;
          if (bc_nxt >= 10'(CLOCK_TRAIN_BYTES)) begin
            cmd_nxt = CMD0; arg_nxt = '0; phase_nxt = PH_PRE; res.cs = 1'b1;
          end
        end
        PH_PRE: begin
          phase_nxt = PH_CMD; bc_nxt = '0;
          res.tr = 1'b1; res.mosi = {2'b01, cmd_r}; res.cs = 1'b1;
        end
        PH_CMD: begin
          bc_nxt = bc_r + 10'd1;
          res.tr = 1'b1; res.cs = 1'b1; res.mosi = 8'hFF;
          if (bc_nxt < 10'd6) begin
            unique case (bc_nxt[2:0])
              3'd1: res.mosi = arg_r[31:24];
              3'd2: res.mosi = arg_r[23:16];
              3'd3: res.mosi = arg_r[15:8];
              3'd4: res.mosi = arg_r[7:0];
              default: res.mosi = (cmd_r == CMD0 || cmd_r == CMD16) ? 8'h95 :
                                  (cmd_r == CMD8) ? 8'h87 : 8'hFF;
            endcase
          end else begin
            phase_nxt = PH_RESP; pc_nxt = '0;
          end
        end
        PH_RESP: begin
          pc_nxt = pc_inc;
          if (miso != 8'hFF) begin rdone = 1'b1; r1v = miso; end
          else if (pc_inc >= {13'd0, rlim}) rdone = 1'b1;
          else begin res.tr = 1'b1; res.mosi = 8'hFF; res.cs = 1'b1; end
        end
        PH_TRAIL: begin
          arg_nxt = {arg_r[23:0], miso};
          bc_nxt = bc_r + 10'd1;
          res.tr = 1'b1; res.mosi = 8'hFF;
          if (bc_nxt < 10'd4) res.cs = 1'b1;
          else begin phase_nxt = PH_DESEL; fs_nxt = ST_OK; end
        end
        PH_DESEL: begin
          res.tr = 1'b1; res.mosi = 8'hFF; res.cs = 1'b1;
          unique case (cmd_r)
            CMD0: if (r1_r == 8'h01) begin cmd_nxt = CMD8; arg_nxt = 32'h1AA;
                    phase_nxt = PH_PRE; end
                  else begin res = '0; res.done = 1'b1; res.status = ST_CMD0; end
            CMD8: if (r1_r == 8'h01 && arg_r[7:0] == 8'hAA) begin
                    orc_nxt = '0; rc_nxt = '0; cmd_nxt = CMD55; arg_nxt = '0;
                    phase_nxt = PH_PRE;
                  end else begin res = '0; res.done = 1'b1; res.status = ST_CMD8; end
            CMD55: if (r1_r <= 8'h01) begin cmd_nxt = CMD41; arg_nxt = 32'h4000_0000;
                     phase_nxt = PH_PRE; end
                   else begin res = '0; res.done = 1'b1; res.status = ST_ACMD41; end
            CMD41: begin
              if (r1_r == 8'h00) begin cmd_nxt = CMD58; arg_nxt = '0; phase_nxt = PH_PRE; end
              else if (rc_r < retry_lim) begin
                rc_nxt = rc_r + 8'd1; cmd_nxt = CMD55; arg_nxt = '0; phase_nxt = PH_PRE;
              end else if (r1_r == 8'h01 && ({1'b0, orc_r} + 5'd1) < 5'(INIT_ROUNDS)) begin
                orc_nxt = orc_r + 4'd1; rc_nxt = '0; cmd_nxt = CMD55; arg_nxt = '0;
                phase_nxt = PH_PRE;
              end else begin
                res = '0; res.done = 1'b1;
                res.status = (r1_r == 8'h01) ? ST_TIMEOUT : ST_ACMD41;
              end
            end
            CMD58: if (r1_r == 8'h00) begin
                     ocr_nxt = arg_r; hc_nxt = arg_r[30];
                     if (arg_r[30]) begin res = '0; res.done = 1'b1; res.status = ST_OK; end
                     else begin cmd_nxt = CMD16; arg_nxt = 32'(BLOCK_BYTES);
                       phase_nxt = PH_PRE; end
                   end else begin res = '0; res.done = 1'b1; res.status = ST_OCR; end
            CMD16: begin res = '0; res.done = 1'b1;
                     res.status = (r1_r == 8'h00) ? ST_OK : ST_CMD16; end
            default: begin res = '0; res.done = 1'b1; res.status = ST_BLOCK; end
          endcase
          if (res.done) phase_nxt = PH_IDLE;
        end
        PH_DESEL_FIN: begin
          phase_nxt = PH_IDLE; res.done = 1'b1; res.status = fs_r;
        end
        PH_RD_TOKEN: begin
          pc_nxt = pc_inc;
          res.tr = 1'b1; res.mosi = 8'hFF; res.cs = 1'b1;
          if (miso == 8'hFE) begin phase_nxt = PH_RD_DATA; bc_nxt = '0; end
          else if (miso != 8'hFF || pc_inc >= {13'd0, rlim}) begin
            phase_nxt = PH_DESEL_FIN; fs_nxt = ST_BLOCK; res.cs = 1'b0;
          end
        end
        PH_RD_DATA: begin
          res.rv = 1'b1; res.rb = miso;
          bc_nxt = bc_r + 10'd1;
          if (bc_r == 10'(BLOCK_BYTES - 1)) begin phase_nxt = PH_RD_CRC; bc_nxt = '0; end
          res.tr = 1'b1; res.mosi = 8'hFF; res.cs = 1'b1;
        end
        PH_RD_CRC: begin
          bc_nxt = bc_r + 10'd1;
          res.tr = 1'b1; res.mosi = 8'hFF; res.cs = 1'b1;
          if (bc_nxt >= 10'd2) begin
            phase_nxt = PH_DESEL_FIN; fs_nxt = ST_OK; res.cs = 1'b0;
          end
        end
        PH_WR_GAP: begin
          phase_nxt = PH_WR_TOKEN;
          res.tr = 1'b1; res.mosi = 8'hFE; res.cs = 1'b1; res.need = 1'b1;
        end
        PH_WR_TOKEN: begin
          phase_nxt = PH_WR_DATA; bc_nxt = 10'd1;
          res.tr = 1'b1; res.mosi = wb; res.cs = 1'b1; res.need = 1'b1;
        end
        PH_WR_DATA: begin
          res.tr = 1'b1; res.cs = 1'b1;
          if (bc_r != 10'(BLOCK_BYTES - 1) + 10'd1 && bc_r < 10'(BLOCK_BYTES - 1) + 10'd1)
          begin
            bc_nxt = bc_r + 10'd1; res.mosi = wb;
            res.need = (bc_r != 10'(BLOCK_BYTES - 1));
          end else begin
            phase_nxt = PH_WR_CRC; bc_nxt = '0; res.mosi = 8'hFF;
          end
        end
        PH_WR_CRC: begin
          bc_nxt = bc_r + 10'd1;
          if (bc_nxt >= 10'd2) phase_nxt = PH_WR_DRESP;
          res.tr = 1'b1; res.mosi = 8'hFF; res.cs = 1'b1;
        end
        PH_WR_DRESP: begin
          res.tr = 1'b1; res.mosi = 8'hFF;
          if (miso[4:0] == 5'h05) begin
            phase_nxt = PH_WR_BUSY; pc_nxt = '0; res.cs = 1'b1;
          end else begin phase_nxt = PH_DESEL_FIN; fs_nxt = ST_BLOCK; end
        end
        PH_WR_BUSY: begin
          pc_nxt = pc_inc;
          res.tr = 1'b1; res.mosi = 8'hFF; res.cs = 1'b1;
          if (miso == 8'hFF) begin phase_nxt = PH_DESEL_FIN; fs_nxt = ST_OK; res.cs = 1'b0; end
          else if (pc_inc >= blim) begin
            phase_nxt = PH_DESEL_FIN; fs_nxt = ST_BLOCK; res.cs = 1'b0;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
      if (rdone) begin
        r1_nxt = r1v;
        res.tr = 1'b1; res.mosi = 8'hFF; res.cs = 1'b1;
        if ((cmd_r == CMD8 && r1v == 8'h01) || (cmd_r == CMD58 && r1v == 8'h00)) begin
          phase_nxt = PH_TRAIL; bc_nxt = '0; arg_nxt = '0;
        end else if (cmd_r == CMD17 || cmd_r == CMD24) begin
          if (r1v != 8'h00) begin
            phase_nxt = PH_DESEL_FIN; fs_nxt = ST_BLOCK; res.cs = 1'b0;
          end else begin
            pc_nxt = '0; phase_nxt = (cmd_r == CMD17) ? PH_RD_TOKEN : PH_WR_GAP;
          end
        end else begin
          phase_nxt = PH_DESEL; fs_nxt = ST_OK; res.cs = 1'b0;
        end
      end
    end
    res.hc = hc_nxt;
    res.ocr = ocr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; bc_r <= '0; pc_r <= '0; rc_r <= '0; orc_r <= '0;
      ocr_r <= '0; hc_r <= 1'b0; arg_r <= '0; cmd_r <= '0; r1_r <= '0; fs_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt; bc_r <= bc_nxt; pc_r <= pc_nxt; rc_r <= rc_nxt;
      orc_r <= orc_nxt; ocr_r <= ocr_nxt; hc_r <= hc_nxt; arg_r <= arg_nxt;
      cmd_r <= cmd_nxt; r1_r <= r1_nxt; fs_r <= fs_nxt;
    end
  end

  `SDS_ASSERT_IMP(a_done_no_tr, step && res.done, !res.tr && !res.cs)
  `SDS_ASSERT_IMP(a_bc_range, 1'b1, bc_r <= 10'(BLOCK_BYTES))
  `SDS_ASSERT_NEXT(a_init_train, step && op == OP_INIT, phase_r == PH_TRAIN)
endmodule
`default_nettype wire

### tb/sv/sds_result_checker.sv
// Result checker for the SD SPI host sequencer: watches the input, result and
// configuration transfers, predicts every result and compares it field by field.
// Depends on sds_pkg for phases, operation, command and status codes.
module sds_result_checker import sds_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [55:0] in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [55:0] out_data,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          results_seen,
  output int          runs_done
);
  timeunit 1ns;
  timeprecision 1ps;

  res_t        expected_results[$];
  res_t        nxt;
  phase_t      ph;
  logic [9:0]  bcnt;
  logic [20:0] pcnt;
  logic [7:0]  rcnt;
  logic [3:0]  outer_cnt;
  logic [31:0] ocr_reg;
  logic        blk_mode;
  logic [31:0] arg;
  logic [5:0]  cur_cmd;
  logic [7:0]  last_resp;
  logic [2:0]  pend_status;
  logic [7:0]  resp_limit;
  logic [7:0]  retry_limit;
  logic [20:0] busy_limit;

  function automatic logic [20:0] at_least_one(logic [20:0] v);
    return (v == 0) ? 21'd1 : v;
  endfunction

  function automatic logic [7:0] cmd_frame_byte(logic [9:0] k);
    if (k == 0) return 8'h40 | {2'b00, cur_cmd};
    if (k <= 4) return 8'(arg >> (8 * (4 - k)));
    if (cur_cmd == CMD0 || cur_cmd == CMD16) return 8'h95;
    if (cur_cmd == CMD8) return 8'h87;
    return 8'hFF;
  endfunction

  task automatic drive_byte(logic [7:0] b, logic sel);
    nxt.tr = 1'b1;
    nxt.mosi = b;
    nxt.cs = sel;
  endtask

  task automatic end_run(logic [2:0] s);
    ph = PH_IDLE;
    nxt.done = 1'b1;
    nxt.status = s;
  endtask

  task automatic release_card(logic [2:0] s, logic fin);
    ph = fin ? PH_DESEL_FIN : PH_DESEL;
    pend_status = s;
    drive_byte(8'hFF, 1'b0);
  endtask

  task automatic issue_cmd(logic [5:0] c, logic [31:0] a);
    cur_cmd = c;
    arg = a;
    ph = PH_PRE;
    drive_byte(8'hFF, 1'b1);
  endtask

  task automatic take_response(logic [7:0] v);
    last_resp = v;
    if ((cur_cmd == CMD8 && v == 8'h01) || (cur_cmd == CMD58 && v == 8'h00)) begin
      ph = PH_TRAIL;
      bcnt = 0;
      arg = 0;
      drive_byte(8'hFF, 1'b1);
    end else if (cur_cmd == CMD17 || cur_cmd == CMD24) begin
      if (v != 8'h00) begin
        release_card(ST_BLOCK, 1'b1);
      end else begin
        pcnt = 0;
        ph = (cur_cmd == CMD17) ? PH_RD_TOKEN : PH_WR_GAP;
        drive_byte(8'hFF, 1'b1);
      end
    end else begin
      release_card(ST_OK, 1'b0);
    end
  endtask

  task automatic next_command();
    case (cur_cmd)
      CMD0: begin
        if (last_resp == 8'h01) issue_cmd(CMD8, 32'h1AA);
        else end_run(ST_CMD0);
      end
      CMD8: begin
        if (last_resp == 8'h01 && arg[7:0] == 8'hAA) begin
          outer_cnt = 0;
          rcnt = 0;
          issue_cmd(CMD55, 32'h0);
        end else begin
          end_run(ST_CMD8);
        end
      end
      CMD55: begin
        if (last_resp <= 8'h01) issue_cmd(CMD41, 32'h4000_0000);
        else end_run(ST_ACMD41);
      end
      CMD41: begin
        if (last_resp == 8'h00) begin
          issue_cmd(CMD58, 32'h0);
        end else if (rcnt < retry_limit) begin
          rcnt++;
          issue_cmd(CMD55, 32'h0);
        end else if (last_resp == 8'h01 && int'(outer_cnt) + 1 < INIT_ROUNDS) begin
          outer_cnt++;
          rcnt = 0;
          issue_cmd(CMD55, 32'h0);
        end else begin
          end_run(last_resp == 8'h01 ? ST_TIMEOUT : ST_ACMD41);
        end
      end
      CMD58: begin
        if (last_resp == 8'h00) begin
          ocr_reg = arg;
          blk_mode = ocr_reg[30];
          if (blk_mode) end_run(ST_OK);
          else issue_cmd(CMD16, BLOCK_BYTES);
        end else begin
          end_run(ST_OCR);
        end
      end
      CMD16: end_run(last_resp == 8'h00 ? ST_OK : ST_CMD16);
      default: end_run(ST_BLOCK);
    endcase
  endtask

  task automatic byte_exchanged(logic [7:0] miso, logic [7:0] wb);
    case (ph)
      PH_TRAIN: begin
        bcnt++;
        if (bcnt < CLOCK_TRAIN_BYTES) drive_byte(8'hFF, 1'b0);
        else issue_cmd(CMD0, 32'h0);
      end
      PH_PRE: begin
        ph = PH_CMD;
        bcnt = 0;
        drive_byte(cmd_frame_byte(0), 1'b1);
      end
      PH_CMD: begin
        bcnt++;
        if (bcnt < 6) begin
          drive_byte(cmd_frame_byte(bcnt), 1'b1);
        end else begin
          ph = PH_RESP;
          pcnt = 0;
          drive_byte(8'hFF, 1'b1);
        end
      end
      PH_RESP: begin
        pcnt++;
        if (miso != 8'hFF) take_response(miso);
        else if (pcnt >= at_least_one({13'd0, resp_limit})) take_response(8'hFF);
        else drive_byte(8'hFF, 1'b1);
      end
      PH_TRAIL: begin
        arg = {arg[23:0], miso};
        bcnt++;
        if (bcnt < 4) drive_byte(8'hFF, 1'b1);
        else release_card(ST_OK, 1'b0);
      end
      PH_DESEL: next_command();
      PH_DESEL_FIN: end_run(pend_status);
      PH_RD_TOKEN: begin
        pcnt++;
        if (miso != 8'hFF) begin
          if (miso == 8'hFE) begin
            ph = PH_RD_DATA;
            bcnt = 0;
            drive_byte(8'hFF, 1'b1);
          end else begin
            release_card(ST_BLOCK, 1'b1);
          end
        end else if (pcnt >= at_least_one({13'd0, resp_limit})) begin
          release_card(ST_BLOCK, 1'b1);
        end else begin
          drive_byte(8'hFF, 1'b1);
        end
      end
      PH_RD_DATA: begin
        nxt.rv = 1'b1;
        nxt.rb = miso;
        bcnt++;
        if (bcnt >= BLOCK_BYTES) begin
          ph = PH_RD_CRC;
          bcnt = 0;
        end
        drive_byte(8'hFF, 1'b1);
      end
      PH_RD_CRC: begin
        bcnt++;
        if (bcnt < 2) drive_byte(8'hFF, 1'b1);
        else release_card(ST_OK, 1'b1);
      end
      PH_WR_GAP: begin
        ph = PH_WR_TOKEN;
        drive_byte(8'hFE, 1'b1);
        nxt.need = 1'b1;
      end
      PH_WR_TOKEN: begin
        ph = PH_WR_DATA;
        bcnt = 1;
        drive_byte(wb, 1'b1);
        nxt.need = (bcnt < BLOCK_BYTES);
      end
      PH_WR_DATA: begin
        if (bcnt < BLOCK_BYTES) begin
          bcnt++;
          drive_byte(wb, 1'b1);
          nxt.need = (bcnt < BLOCK_BYTES);
        end else begin
          ph = PH_WR_CRC;
          bcnt = 0;
          drive_byte(8'hFF, 1'b1);
        end
      end
      PH_WR_CRC: begin
        bcnt++;
        if (bcnt >= 2) ph = PH_WR_DRESP;
        drive_byte(8'hFF, 1'b1);
      end
      PH_WR_DRESP: begin
        if (miso[4:0] == 5'h05) begin
          ph = PH_WR_BUSY;
          pcnt = 0;
          drive_byte(8'hFF, 1'b1);
        end else begin
          release_card(ST_BLOCK, 1'b1);
        end
      end
      PH_WR_BUSY: begin
        pcnt++;
        if (miso == 8'hFF) release_card(ST_OK, 1'b1);
        else if (pcnt >= at_least_one(busy_limit)) release_card(ST_BLOCK, 1'b1);
        else drive_byte(8'hFF, 1'b1);
      end
      default: ph = PH_IDLE;
    endcase
  endtask

  task automatic sequencer_step(logic [55:0] d);
    op_t         op;
    logic [31:0] addr;
    op = op_t'(d[1:0]);
    addr = d[33:2];
    nxt = '0;
    case (op)
      OP_INIT: begin
        ph = PH_TRAIN;
        bcnt = 0;
        drive_byte(8'hFF, 1'b0);
      end
      OP_READ, OP_WRITE: begin
        issue_cmd(op == OP_READ ? CMD17 : CMD24,
                  blk_mode ? addr : addr * BLOCK_BYTES);
      end
      default: begin
        if (ph != PH_IDLE) byte_exchanged(d[41:34], d[49:42]);
      end
    endcase
    nxt.hc = blk_mode;
    nxt.ocr = ocr_reg;
    expected_results.push_back(nxt);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (!rst_n) begin
      ph = PH_IDLE;
      bcnt = 0;
      pcnt = 0;
      rcnt = 0;
      outer_cnt = 0;
      ocr_reg = 0;
      blk_mode = 0;
      arg = 0;
      cur_cmd = CMD0;
      last_resp = 0;
      pend_status = ST_OK;
      resp_limit = 8'd50;
      retry_limit = 8'd25;
      busy_limit = 21'd1300000;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_last) runs_done++;
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result: expected none actual %0h", $realtime, out_data);
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("transfer_request", e.tr, out_data[0]);
          check_field("mosi_byte", e.mosi, out_data[8:1]);
          check_field("chip_select_active", e.cs, out_data[9]);
          check_field("read_valid", e.rv, out_data[10]);
          check_field("read_byte", e.rb, out_data[18:11]);
          check_field("need_write_byte", e.need, out_data[19]);
          check_field("done_res", e.done, out_last);
          check_field("status", e.status, out_data[22:20]);
          check_field("high_capacity", e.hc, out_data[23]);
          check_field("ocr_value", e.ocr, out_data[55:24]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_RESP_POLL: resp_limit = cfg_data[7:0];
          CFG_RETRY:     retry_limit = cfg_data[7:0];
          CFG_BUSY_POLL: busy_limit = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) sequencer_step(in_data);
    end
    pending = expected_results.size();
  end

  initial begin
    errors = 0;
    pending = 0;
    results_seen = 0;
    runs_done = 0;
  end
endmodule

### tb/sv/testbench.sv
// Top of the SD SPI host sequencer testbench: clock, reset, card-like byte
// scripts for init, block read and block write, and the verdict.
// Depends on sds_pkg, sd_spi_host_sequencer_top and sds_result_checker.
module testbench import sds_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [20:0] cfg_data;
  int          errors;
  int          pending;
  int          results_seen;
  int          runs_done;
  int          items_sent;
  int          settings_used;
  bit          quiet;
  bit          long_hold;
  logic [7:0]  cur_resp;
  logic [7:0]  cur_retry;

  sd_spi_host_sequencer_top dut (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sds_result_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata),
    .out_last(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .results_seen(results_seen),
    .runs_done(runs_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic send_item(op_t op, logic [31:0] addr, logic [7:0] miso);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, 8'($urandom()), miso, addr, op};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic xfer(logic [7:0] miso);
    send_item(OP_XFER, $urandom(), miso);
  endtask

  task automatic xfer_any(int n);
    repeat (n) xfer(8'($urandom()));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [20:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(logic [7:0] rp, logic [7:0] rt, logic [20:0] bp);
    wait_idle();
    cfg_write(CFG_RESP_POLL, {13'd0, rp});
    cfg_write(CFG_RETRY, {13'd0, rt});
    cfg_write(CFG_BUSY_POLL, bp);
    cur_resp = rp;
    cur_retry = rt;
    settings_used++;
  endtask

  function automatic logic [7:0] mostly(logic [7:0] good);
    return ($urandom_range(0, 9) == 0) ? 8'($urandom()) : good;
  endfunction

  function automatic int poll_gap();
    return ($urandom_range(0, 19) == 0) ? int'(cur_resp) : $urandom_range(0, 3);
  endfunction

  // one command frame: pre byte, six command bytes, response poll, trailer, deselect
  task automatic card_cmd(logic [7:0] r1, bit trail, logic [31:0] tdat);
    xfer_any(7);
    repeat (poll_gap()) xfer(8'hFF);
    xfer(r1);
    if (trail) begin
      for (int i = 3; i >= 0; i--) xfer(tdat[8*i +: 8]);
    end
    xfer_any(1);
  endtask

  task automatic card_init();
    logic [7:0]  r1;
    logic [31:0] ocr;
    int          ones;
    int          max_rounds;
    send_item(OP_INIT, $urandom(), 8'($urandom()));
    xfer_any(CLOCK_TRAIN_BYTES);
    r1 = mostly(8'h01);
    card_cmd(r1, 1'b0, 0);
    if (r1 != 8'h01) return;
    card_cmd(8'h01, 1'b1, {24'($urandom_range(0, 'hFFFFFF)), mostly(8'hAA)});
    max_rounds = INIT_ROUNDS * (int'(cur_retry) + 1);
    ones = $urandom_range(0, 3);
    if (cur_retry <= 3 && $urandom_range(0, 5) == 0) ones = max_rounds;
    for (int i = 0; i < ones && i < max_rounds; i++) begin
      card_cmd(8'($urandom_range(0, 1)), 1'b0, 0);
      card_cmd(8'h01, 1'b0, 0);
    end
    if (ones >= max_rounds) return;
    r1 = mostly(8'h01);
    card_cmd(r1, 1'b0, 0);
    if (r1 > 8'h01) return;
    card_cmd(mostly(8'h00), 1'b0, 0);
    ocr = $urandom();
    r1 = mostly(8'h00);
    card_cmd(r1, 1'b1, ocr);
    if (r1 != 8'h00 || ocr[30]) return;
    card_cmd(mostly(8'h00), 1'b0, 0);
  endtask

  task automatic card_read();
    send_item(OP_READ, $urandom(), 8'($urandom()));
    card_cmd(mostly(8'h00), 1'b0, 0);
    repeat (poll_gap()) xfer(8'hFF);
    xfer(mostly(8'hFE));
    xfer_any(BLOCK_BYTES + 3);
  endtask

  task automatic card_write();
    int busy;
    send_item(OP_WRITE, $urandom(), 8'($urandom()));
    card_cmd(mostly(8'h00), 1'b0, 0);
    xfer_any(BLOCK_BYTES + 3);
    xfer(mostly({3'($urandom()), 5'h05}));
    busy = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
    repeat (busy) xfer(8'($urandom_range(0, 8'hFE)));
    xfer(8'hFF);
    xfer_any(1);
  endtask

  task automatic noise();
    repeat ($urandom_range(3, 12)) begin
      if ($urandom_range(0, 5) == 0) begin
        send_item(op_t'($urandom_range(0, 2)), $urandom(), 8'($urandom()));
      end else begin
        xfer(8'($urandom()));
      end
    end
  endtask

  task automatic random_phase(int stop_at);
    int pick;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      // keep block transfers to phases with room for a whole block
      if (pick >= 4 && pick < 8 && stop_at - items_sent < BLOCK_BYTES + 40) begin
        pick = (pick < 6) ? 0 : 8;
      end
      if (pick < 4) card_init();
      else if (pick < 6) card_read();
      else if (pick < 8) card_write();
      else noise();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_RESP_POLL;
    cfg_data <= '0;
    quiet = 1'b0;
    long_hold = 1'b0;
    items_sent = 0;
    settings_used = 1;
    cur_resp = 8'd50;
    cur_retry = 8'd25;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle exchanges, address extremes, aborts of running work
    xfer(8'h00);
    xfer(8'hFF);
    send_item(OP_READ, 32'h0000_0000, 8'h00);
    send_item(OP_WRITE, 32'hFFFF_FFFF, 8'hFF);
    xfer_any(3);
    send_item(OP_INIT, 32'h8000_0001, 8'h5A);
    xfer_any(2);
    send_item(OP_READ, 32'h7FFF_FFFF, 8'hA5);
    send_item(OP_INIT, 32'h0, 8'h0);
    xfer_any(CLOCK_TRAIN_BYTES + 7);
    xfer(8'h00);
    xfer_any(2);

    random_phase(items_sent + 100);
    long_hold = 1'b1;
    card_read();
    set_limits(8'd255, 8'd255, 21'h1FFFFF);
    random_phase(items_sent + 150);
    set_limits(8'd0, 8'd0, 21'd0);
    random_phase(items_sent + 600);
    set_limits(8'd1, 8'd1, 21'd2);
    random_phase(items_sent + 150);
    set_limits(8'($urandom_range(2, 6)), 8'($urandom_range(1, 3)),
               21'($urandom_range(1, 8)));
    random_phase(items_sent + 150);
    quiet = 1'b1;
    random_phase(items_sent + 100);

    wait_idle();
    repeat (10) @(posedge clk);
    $display("covered %0d input items over %0d limit settings", items_sent, settings_used);
    $display("checked %0d results, %0d finished runs", results_seen, runs_done);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
